FILE: rtl/tswc_pkg.sv
package tswc_pkg;

  localparam int PRE_DEPTH = 32;

  localparam int TIME_W   = 32;
  localparam int VOLT_W   = 16;
  localparam int IDX_W    = 20;
  localparam int PRE_W    = 16;
  localparam int POST_W   = 16;
  localparam int OFF_W    = 21;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;
  localparam int FILL_W   = $clog2(PRE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_INDEX = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRE_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POST_WINDOW   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK          = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_TRIGGER  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TRUNCATED   = 2'd2;

  localparam logic [PRE_W-1:0]  PRE_RESET  = 16'd1000;
  localparam logic [POST_W-1:0] POST_RESET = 16'd3000;

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_POST,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BURST,
    ST_TRIG,
    ST_LAST
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]        stamp;
    logic signed [VOLT_W-1:0] volt;
  } sample_t;

endpackage

FILE: rtl/tswc_if.sv
interface tswc_in_if import tswc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        sample_time;
  logic signed [VOLT_W-1:0] sample_voltage;
  logic                     end_of_record;

  modport source (output valid, sample_time, sample_voltage, end_of_record, input ready);
  modport sink   (input valid, sample_time, sample_voltage, end_of_record, output ready);
endinterface

interface tswc_out_if import tswc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TIME_W-1:0]        relative_time;
  logic signed [VOLT_W-1:0] window_voltage;
  logic                     last_of_window;
  logic signed [OFF_W-1:0]  peak_offset;
  logic [STAT_W-1:0]        capture_status;

  modport source (output valid, relative_time, window_voltage, last_of_window, peak_offset,
                  capture_status, input ready);
  modport sink   (input valid, relative_time, window_voltage, last_of_window, peak_offset,
                  capture_status, output ready);
endinterface

FILE: rtl/triggered_spike_window_capture.sv
// Pre/post trigger window capture with peak search.
// Input channel in_if carries timestamped voltage samples of a record, one
// transaction per sample; end_of_record closes the record. Output channel
// out_if carries the window samples; last_of_window marks the final one,
// which also carries peak_offset and capture_status. The config port
// (cfg_we_i, cfg_idx_i, cfg_data_i) writes trigger index, pre and post
// window widths, one register per cycle; the user must write only while
// no capture is in flight, which the block does not enforce. Outside the
// trigger, one sample is taken per cycle; a result it causes is registered
// onto out_if in the next cycle. The trigger sample starts a drain of the
// pre-trigger shift chain: one cell position per cycle through PRE_DEPTH
// cells, then a closing step, with no sample taken. A sample in the post
// window that ends the record needs an extra step for its second result.
// Reset clears counters, phase, fill and peak; the chain contents are
// don't-care until written. When out_if stalls, the single output register
// holds and both input and drain pause until the result is taken.
module triggered_spike_window_capture import tswc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tswc_in_if.sink              in_if,
  tswc_out_if.source           out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic [IDX_W-1:0]  trig_index_q;
  logic [PRE_W-1:0]  pre_ticks_q;
  logic [POST_W-1:0] post_ticks_q;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [FILL_W-1:0]        step_q, step_d;
  logic [IDX_W-1:0]         count_q, count_d;
  logic [IDX_W-1:0]         eidx_q, eidx_d;
  logic [TIME_W-1:0]        trig_time_q, trig_time_d;
  logic signed [VOLT_W-1:0] trig_volt_q, trig_volt_d;
  logic                     trig_eor_q, trig_eor_d;
  logic [IDX_W-1:0]         trig_idx_q, trig_idx_d;
  logic [TIME_W-1:0]        start_q, start_d;
  logic [TIME_W:0]          end_q, end_d;
  logic [TIME_W-1:0]        wft_q, wft_d;
  logic [TIME_W-1:0]        held_time_q, held_time_d;
  logic signed [VOLT_W-1:0] held_volt_q, held_volt_d;
  logic signed [VOLT_W-1:0] peak_val_q, peak_val_d;
  logic [IDX_W-1:0]         peak_pos_q, peak_pos_d;
  logic                     trunc_q, trunc_d;
  logic                     first_q, first_d;

  logic                     o_valid_q;
  logic [TIME_W-1:0]        o_time_q;
  logic signed [VOLT_W-1:0] o_volt_q;
  logic                     o_last_q;
  logic signed [OFF_W-1:0]  o_off_q;
  logic [STAT_W-1:0]        o_stat_q;

  logic                     out_free, in_acc, shift;
  logic                     emit, e_last, e_no_trig;
  logic [TIME_W-1:0]        e_time;
  logic signed [VOLT_W-1:0] e_volt;
  logic [TIME_W-1:0]        start_c;
  logic                     tail_valid;
  sample_t                  head, tail;

  assign out_free = !o_valid_q || out_if.ready;
  assign in_if.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc = in_if.valid && in_if.ready;

  assign head.stamp = in_if.sample_time;
  assign head.volt  = in_if.sample_voltage;

  assign start_c = (in_if.sample_time > TIME_W'(pre_ticks_q))
                   ? in_if.sample_time - TIME_W'(pre_ticks_q) : '0;
  assign tail_valid = ({1'b0, step_q} + {1'b0, fill_q}) >= (FILL_W+1)'(PRE_DEPTH);

  tswc_ring u_ring (
    .clk_i  (clk_i),
    .shift_i(shift),
    .head_i (head),
    .tail_o (tail)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_index_q <= '0;
      pre_ticks_q  <= PRE_RESET;
      post_ticks_q <= POST_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TRIGGER_INDEX: trig_index_q <= cfg_data_i[IDX_W-1:0];
        CFG_PRE_WINDOW:    pre_ticks_q  <= cfg_data_i[PRE_W-1:0];
        CFG_POST_WINDOW:   post_ticks_q <= cfg_data_i[POST_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    fill_d      = fill_q;
    step_d      = step_q;
    count_d     = count_q;
    eidx_d      = eidx_q;
    trig_time_d = trig_time_q;
    trig_volt_d = trig_volt_q;
    trig_eor_d  = trig_eor_q;
    trig_idx_d  = trig_idx_q;
    start_d     = start_q;
    end_d       = end_q;
    wft_d       = wft_q;
    held_time_d = held_time_q;
    held_volt_d = held_volt_q;
    peak_val_d  = peak_val_q;
    peak_pos_d  = peak_pos_q;
    trunc_d     = trunc_q;
    first_d     = first_q;
    shift       = 1'b0;
    emit        = 1'b0;
    e_last      = 1'b0;
    e_no_trig   = 1'b0;
    e_time      = held_time_q;
    e_volt      = held_volt_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          count_d = in_if.end_of_record ? '0 : count_q + 1'b1;
          case (phase_q)
            PH_WAIT: begin
              if (count_q == trig_index_q) begin
                trig_time_d = in_if.sample_time;
                trig_volt_d = in_if.sample_voltage;
                trig_eor_d  = in_if.end_of_record;
                trig_idx_d  = count_q;
                start_d     = start_c;
                end_d       = {1'b0, in_if.sample_time} + (TIME_W+1)'(post_ticks_q);
                trunc_d     = (fill_q == FILL_W'(PRE_DEPTH)) &&
                              (count_q > IDX_W'(fill_q)) && (tail.stamp >= start_c);
                eidx_d      = count_q - IDX_W'(PRE_DEPTH);
                step_d      = '0;
                first_d     = 1'b1;
                state_d     = ST_BURST;
              end else begin
                shift = 1'b1;
                if (fill_q < FILL_W'(PRE_DEPTH)) begin
                  fill_d = fill_q + 1'b1;
                end
                if (in_if.end_of_record) begin
                  emit      = 1'b1;
                  e_last    = 1'b1;
                  e_no_trig = 1'b1;
                  fill_d    = '0;
                end
              end
            end
            PH_POST: begin
              emit = 1'b1;
              if ({1'b0, in_if.sample_time} <= end_q) begin
                if (in_if.sample_voltage > peak_val_q) begin
                  peak_val_d = in_if.sample_voltage;
                  peak_pos_d = count_q;
                end
                held_time_d = in_if.sample_time;
                held_volt_d = in_if.sample_voltage;
                if (in_if.end_of_record) begin
                  state_d = ST_LAST;
                end
              end else begin
                e_last  = 1'b1;
                phase_d = PH_DONE;
              end
              if (in_if.end_of_record) begin
                phase_d = PH_WAIT;
                fill_d  = '0;
              end
            end
            default: begin
              if (in_if.end_of_record) begin
                phase_d = PH_WAIT;
                fill_d  = '0;
              end
            end
          endcase
        end
      end

      ST_BURST: begin
        if (out_free) begin
          shift  = 1'b1;
          step_d = step_q + 1'b1;
          eidx_d = eidx_q + 1'b1;
          e_time = tail.stamp;
          e_volt = tail.volt;
          if (tail_valid && (tail.stamp >= start_q)) begin
            emit = 1'b1;
            if (first_q) begin
              first_d    = 1'b0;
              wft_d      = tail.stamp;
              peak_val_d = tail.volt;
              peak_pos_d = eidx_q;
            end else if (tail.volt > peak_val_q) begin
              peak_val_d = tail.volt;
              peak_pos_d = eidx_q;
            end
          end
          if (step_q == FILL_W'(PRE_DEPTH - 1)) begin
            state_d = ST_TRIG;
          end
        end
      end

      ST_TRIG: begin
        if (out_free) begin
          if (first_q) begin
            wft_d      = trig_time_q;
            peak_val_d = trig_volt_q;
            peak_pos_d = trig_idx_q;
          end else if (trig_volt_q > peak_val_q) begin
            peak_val_d = trig_volt_q;
            peak_pos_d = trig_idx_q;
          end
          held_time_d = trig_time_q;
          held_volt_d = trig_volt_q;
          if (trig_eor_q) begin
            emit    = 1'b1;
            e_last  = 1'b1;
            e_time  = trig_time_q;
            e_volt  = trig_volt_q;
            phase_d = PH_WAIT;
            fill_d  = '0;
          end else begin
            phase_d = PH_POST;
          end
          state_d = ST_IDLE;
        end
      end

      ST_LAST: begin
        if (out_free) begin
          emit    = 1'b1;
          e_last  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_WAIT;
      fill_q      <= '0;
      step_q      <= '0;
      count_q     <= '0;
      eidx_q      <= '0;
      trig_eor_q  <= 1'b0;
      trig_idx_q  <= '0;
      start_q     <= '0;
      end_q       <= '0;
      wft_q       <= '0;
      held_time_q <= '0;
      held_volt_q <= '0;
      peak_val_q  <= {1'b1, {(VOLT_W-1){1'b0}}};
      peak_pos_q  <= '0;
      trunc_q     <= 1'b0;
      first_q     <= 1'b0;
      o_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      fill_q      <= fill_d;
      step_q      <= step_d;
      count_q     <= count_d;
      eidx_q      <= eidx_d;
      trig_eor_q  <= trig_eor_d;
      trig_idx_q  <= trig_idx_d;
      start_q     <= start_d;
      end_q       <= end_d;
      wft_q       <= wft_d;
      held_time_q <= held_time_d;
      held_volt_q <= held_volt_d;
      peak_val_q  <= peak_val_d;
      peak_pos_q  <= peak_pos_d;
      trunc_q     <= trunc_d;
      first_q     <= first_d;
      if (out_free) begin
        o_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    trig_time_q <= trig_time_d;
    trig_volt_q <= trig_volt_d;
    if (out_free && emit) begin
      o_last_q <= e_last;
      if (e_no_trig) begin
        o_time_q <= '0;
        o_volt_q <= '0;
        o_off_q  <= '0;
        o_stat_q <= STAT_NO_TRIGGER;
      end else begin
        o_time_q <= e_time - wft_d;
        o_volt_q <= e_volt;
        if (e_last) begin
          o_off_q  <= OFF_W'({1'b0, peak_pos_d} - {1'b0, trig_index_q});
          o_stat_q <= trunc_q ? STAT_TRUNCATED : STAT_OK;
        end else begin
          o_off_q  <= '0;
          o_stat_q <= STAT_OK;
        end
      end
    end
  end

  assign out_if.valid          = o_valid_q;
  assign out_if.relative_time  = o_time_q;
  assign out_if.window_voltage = o_volt_q;
  assign out_if.last_of_window = o_last_q;
  assign out_if.peak_offset    = o_off_q;
  assign out_if.capture_status = o_stat_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(PRE_DEPTH))
    else $error("pre-trigger fill exceeds chain depth");

  a_burst_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST || state_q == ST_TRIG) |-> phase_q == PH_WAIT)
    else $error("chain drain outside the waiting phase");

  a_mid_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_valid_q && !o_last_q) |-> (o_stat_q == STAT_OK && o_off_q == '0))
    else $error("status or peak offset set on a non-final result");

  a_no_trigger: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_WAIT && count_q != trig_index_q && in_if.end_of_record)
    |=> (o_valid_q && o_last_q && o_stat_q == STAT_NO_TRIGGER))
    else $error("record without trigger did not report status");

endmodule

FILE: rtl/tswc_cell.sv
module tswc_cell import tswc_pkg::*; (
  input  logic    clk_i,
  input  logic    shift_i,
  input  sample_t data_i,
  output sample_t data_o
);

  sample_t data_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

FILE: rtl/tswc_ring.sv
module tswc_ring import tswc_pkg::*; (
  input  logic    clk_i,
  input  logic    shift_i,
  input  sample_t head_i,
  output sample_t tail_o
);

  // link[k] feeds cell k; link[PRE_DEPTH] is the oldest position
  sample_t link [PRE_DEPTH+1];

  assign link[0] = head_i;

  for (genvar k = 0; k < PRE_DEPTH; k++) begin : g_cell
    tswc_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift_i),
      .data_i (link[k]),
      .data_o (link[k+1])
    );
  end

  assign tail_o = link[PRE_DEPTH];

endmodule

FILE: tb/sv/triggered_spike_window_capture_tb.sv
module triggered_spike_window_capture_tb import tswc_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = PRE_DEPTH + 8;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int ITEMS_PER_MODE = 12;

  typedef struct {
    logic [TIME_W-1:0]        rel;
    logic signed [VOLT_W-1:0] volt;
    logic                     is_last;
    logic signed [OFF_W-1:0]  off;
    logic [STAT_W-1:0]        stat;
  } window_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  tswc_in_if  in_ch ();
  tswc_out_if out_ch ();

  triggered_spike_window_capture dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_ch),
    .out_if     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Capture predictor state
  logic [IDX_W-1:0]         trig_idx;
  logic [PRE_W-1:0]         pre_ticks;
  logic [POST_W-1:0]        post_ticks;
  logic [TIME_W-1:0]        ring_time [PRE_DEPTH];
  logic signed [VOLT_W-1:0] ring_volt [PRE_DEPTH];
  int                       ring_count;
  int                       ring_wr;
  logic [IDX_W-1:0]         sample_idx;
  phase_e                   phase;
  logic [TIME_W-1:0]        first_time;
  logic [TIME_W:0]          end_time;
  logic [TIME_W-1:0]        held_time;
  logic signed [VOLT_W-1:0] held_volt;
  logic signed [VOLT_W-1:0] peak_val;
  logic [IDX_W-1:0]         peak_pos;
  logic                     truncated;

  window_result_t pending_window_q[$];
  int error_count;
  int cycle_count;
  int live_items;
  int idle_pct;
  int stall_pct;

  always #5ns clk_i = ~clk_i;

  function automatic void reset_model();
    trig_idx   = '0;
    pre_ticks  = PRE_RESET;
    post_ticks = POST_RESET;
    ring_count = 0;
    ring_wr    = 0;
    sample_idx = '0;
    phase      = PH_WAIT;
    first_time = '0;
    end_time   = '0;
    held_time  = '0;
    held_volt  = '0;
    peak_val   = 16'sh8000;
    peak_pos   = '0;
    truncated  = 1'b0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] data);
    case (idx)
      CFG_TRIGGER_INDEX: trig_idx = data[IDX_W-1:0];
      CFG_PRE_WINDOW:    pre_ticks = data[PRE_W-1:0];
      CFG_POST_WINDOW:   post_ticks = data[POST_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic void append_result(input window_result_t r);
    pending_window_q = {pending_window_q, r};
  endfunction

  function automatic void add_window_sample(input logic [TIME_W-1:0] t,
                                            input logic signed [VOLT_W-1:0] v,
                                            input logic is_last);
    window_result_t r;
    logic [OFF_W-1:0] diff;
    diff = {1'b0, peak_pos} - {1'b0, trig_idx};
    r.rel     = t - first_time;
    r.volt    = v;
    r.is_last = is_last;
    r.off     = is_last ? diff : '0;
    r.stat    = (is_last && truncated) ? STAT_TRUNCATED : STAT_OK;
    append_result(r);
  endfunction

  function automatic void track_peak(input logic signed [VOLT_W-1:0] v,
                                     input logic [IDX_W-1:0] idx);
    if (v > peak_val) begin
      peak_val = v;
      peak_pos = idx;
    end
  endfunction

  function automatic void predict_capture(input logic [TIME_W-1:0] t,
                                          input logic signed [VOLT_W-1:0] v,
                                          input logic eor);
    logic [TIME_W-1:0] start;
    logic [IDX_W-1:0] eidx;
    window_result_t r;
    int oldest;
    int pos;
    bit first;
    first = 1'b1;
    if (phase != PH_DONE) live_items++;
    if (phase == PH_WAIT) begin
      if (sample_idx == trig_idx) begin
        start = (t > pre_ticks) ? t - pre_ticks : '0;
        oldest = (ring_wr + PRE_DEPTH - ring_count) % PRE_DEPTH;
        truncated = (ring_count == PRE_DEPTH) && (sample_idx > ring_count) &&
                    (ring_time[oldest] >= start);
        for (int k = 0; k < ring_count; k++) begin
          pos = (oldest + k) % PRE_DEPTH;
          eidx = sample_idx - IDX_W'(ring_count) + IDX_W'(k);
          if (ring_time[pos] >= start) begin
            if (first) begin
              first = 1'b0;
              first_time = ring_time[pos];
              peak_val = ring_volt[pos];
              peak_pos = eidx;
            end else begin
              track_peak(ring_volt[pos], eidx);
            end
            add_window_sample(ring_time[pos], ring_volt[pos], 1'b0);
          end
        end
        if (first) begin
          first_time = t;
          peak_val = v;
          peak_pos = sample_idx;
        end else begin
          track_peak(v, sample_idx);
        end
        end_time  = {1'b0, t} + post_ticks;
        held_time = t;
        held_volt = v;
        if (eor) add_window_sample(held_time, held_volt, 1'b1);
        else phase = PH_POST;
      end else begin
        ring_time[ring_wr] = t;
        ring_volt[ring_wr] = v;
        ring_wr = (ring_wr + 1) % PRE_DEPTH;
        if (ring_count < PRE_DEPTH) ring_count++;
        if (eor) begin
          r.rel = '0;
          r.volt = '0;
          r.is_last = 1'b1;
          r.off = '0;
          r.stat = STAT_NO_TRIGGER;
          append_result(r);
        end
      end
    end else if (phase == PH_POST) begin
      if ({1'b0, t} <= end_time) begin
        add_window_sample(held_time, held_volt, 1'b0);
        track_peak(v, sample_idx);
        held_time = t;
        held_volt = v;
        if (eor) add_window_sample(held_time, held_volt, 1'b1);
      end else begin
        add_window_sample(held_time, held_volt, 1'b1);
        phase = PH_DONE;
      end
    end
    if (eor) begin
      sample_idx = '0;
      ring_count = 0;
      ring_wr = 0;
      phase = PH_WAIT;
    end else begin
      sample_idx = sample_idx + 1'b1;
    end
  endfunction

  // Result checker: compare each output transaction with the oldest prediction
  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_window_q.size() == 0) begin
        $display("%0t: result with none predicted: got rel=%0h volt=%0d last=%0b off=%0d stat=%0d",
                 $time, out_ch.relative_time, out_ch.window_voltage, out_ch.last_of_window,
                 out_ch.peak_offset, out_ch.capture_status);
        error_count++;
      end else begin
        want = pending_window_q.pop_front();
        if (out_ch.relative_time !== want.rel || out_ch.window_voltage !== want.volt ||
            out_ch.last_of_window !== want.is_last || out_ch.peak_offset !== want.off ||
            out_ch.capture_status !== want.stat) begin
          $display("%0t: mismatch: expected rel=%0h volt=%0d last=%0b off=%0d stat=%0d",
                   $time, want.rel, want.volt, want.is_last, want.off, want.stat);
          $display("%0t:           actual rel=%0h volt=%0d last=%0b off=%0d stat=%0d",
                   $time, out_ch.relative_time, out_ch.window_voltage,
                   out_ch.last_of_window, out_ch.peak_offset, out_ch.capture_status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_window_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_sample(input logic [TIME_W-1:0] t, input logic signed [VOLT_W-1:0] v,
                             input logic eor);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid          <= 1'b1;
    in_ch.sample_time    <= t;
    in_ch.sample_voltage <= v;
    in_ch.end_of_record  <= eor;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_capture(t, v, eor);
  endtask

  // Drop valid, wait for every predicted result, then let the block drain
  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_window_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    settle();
    // trigger at index 0 with an empty ring, close on the first late sample
    send_sample(32'd5000, 16'sh8000, 1'b0);
    send_sample(32'd6000, 16'sh7fff, 1'b0);
    send_sample(32'd8000, 16'sd0, 1'b0);
    send_sample(32'd8001, 16'sd1, 1'b0);
    send_sample(32'd0, 16'sd5, 1'b1);
  endtask

  task automatic test_missing_trigger();
    settle();
    write_register(CFG_TRIGGER_INDEX, 20'd10);
    send_sample(32'd1, -16'sd3, 1'b0);
    send_sample(32'd2, 16'sd4, 1'b0);
    send_sample(32'd3, 16'sd5, 1'b1);
  endtask

  task automatic test_trigger_closes_record();
    settle();
    write_register(CFG_TRIGGER_INDEX, 20'd2);
    write_register(CFG_PRE_WINDOW, 20'h00000);
    write_register(CFG_POST_WINDOW, 20'h0ffff);
    send_sample(32'd100, 16'sd1, 1'b0);
    send_sample(32'd100, -16'sd1, 1'b0);
    send_sample(32'd100, 16'sd7, 1'b1);
    settle();
    // trigger at the top of the time range, window end beyond 32 bits
    write_register(CFG_TRIGGER_INDEX, 20'd0);
    send_sample(32'hffff_ffff, 16'sh7fff, 1'b0);
    send_sample(32'hffff_ffff, 16'sh8000, 1'b0);
    send_sample(32'h0000_0000, 16'sd3, 1'b1);
  endtask

  task automatic test_pre_truncation();
    logic [PRE_W-1:0] widths [2];
    widths[0] = 16'hffff;
    widths[1] = 16'd5;
    foreach (widths[w]) begin
      settle();
      write_register(CFG_TRIGGER_INDEX, 20'd40);
      write_register(CFG_PRE_WINDOW, {4'hf, widths[w]});
      write_register(CFG_POST_WINDOW, 20'd20);
      for (int i = 0; i < 40; i++) send_sample(32'd1000 + i, VOLT_W'(i - 20), 1'b0);
      send_sample(32'd1040, 16'sd100, 1'b0);
      send_sample(32'd1060, 16'sd100, 1'b1);
    end
  endtask

  task automatic test_unordered_times();
    settle();
    write_register(CFG_TRIGGER_INDEX, 20'd3);
    write_register(CFG_PRE_WINDOW, 20'd10);
    write_register(CFG_POST_WINDOW, 20'd20);
    send_sample(32'd50, 16'sd9, 1'b0);
    send_sample(32'd5, 16'sd90, 1'b0);
    send_sample(32'd48, 16'sd9, 1'b0);
    send_sample(32'd50, -16'sd2, 1'b0);
    send_sample(32'd30, 16'sd11, 1'b0);
    send_sample(32'd75, 16'sd500, 1'b0);
    send_sample(32'd60, 16'sd1, 1'b1);
  endtask

  task automatic test_register_extremes();
    settle();
    write_register(CFG_UNUSED, CFG_W'($urandom()));
    write_register(CFG_TRIGGER_INDEX, 20'd1);
    write_register(CFG_PRE_WINDOW, 20'h00000);
    write_register(CFG_POST_WINDOW, 20'hf0000);
    send_sample(32'd10, 16'sd1, 1'b0);
    send_sample(32'd10, 16'sd2, 1'b0);
    send_sample(32'd10, 16'sd2, 1'b0);
    send_sample(32'd11, 16'sd3, 1'b0);
    send_sample(32'd11, 16'sd4, 1'b1);
  endtask

  // Peak lies in the pre window and repeats later, so the first one gives a negative offset
  task automatic test_peak_before_trigger();
    settle();
    write_register(CFG_TRIGGER_INDEX, 20'd6);
    write_register(CFG_PRE_WINDOW, 20'd100);
    write_register(CFG_POST_WINDOW, 20'd3);
    for (int i = 0; i < 6; i++) send_sample(32'd10 + i, (i == 2) ? 16'sd900 : 16'sd1, 1'b0);
    send_sample(32'd16, 16'sd900, 1'b0);
    send_sample(32'd18, 16'sd900, 1'b0);
    send_sample(32'd25, -16'sd1, 1'b0);
    send_sample(32'd26, 16'sd0, 1'b1);
  endtask

  task automatic test_random_records();
    int modes [4][2];
    int target;
    int len;
    logic [TIME_W-1:0] stamp;
    logic [IDX_W-1:0] trig;
    logic [PRE_W-1:0] widths [2];
    modes = '{'{0, 0}, '{51, 0}, '{0, 51}, '{26, 26}};
    foreach (modes[m]) begin
      idle_pct = modes[m][0];
      stall_pct = modes[m][1];
      target = live_items + ITEMS_PER_MODE;
      while (live_items < target) begin
        settle();
        len = $urandom_range(1, 36);
        case ($urandom_range(9))
          0: trig = IDX_W'($urandom());
          1: trig = IDX_W'($urandom_range(len, len + 5));
          default: trig = IDX_W'($urandom_range(0, len - 1));
        endcase
        foreach (widths[w]) begin
          case ($urandom_range(5))
            0: widths[w] = '0;
            1: widths[w] = '1;
            2: widths[w] = PRE_W'($urandom());
            3: widths[w] = PRE_W'($urandom_range(0, 300));
            default: widths[w] = PRE_W'($urandom_range(0, 20));
          endcase
        end
        write_register(CFG_TRIGGER_INDEX, trig);
        write_register(CFG_PRE_WINDOW, {4'($urandom()), widths[0]});
        write_register(CFG_POST_WINDOW, {4'($urandom()), widths[1]});
        stamp = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(0, 200);
        for (int n = 0; n < len; n++) begin
          // mostly nondecreasing times, now and then an arbitrary jump
          if ($urandom_range(9) == 0) stamp = $urandom();
          else stamp += $urandom_range(0, 12);
          send_sample(stamp, VOLT_W'($urandom()), n == len - 1);
        end
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample_time = '0;
    in_ch.sample_voltage = '0;
    in_ch.end_of_record = 1'b0;
    live_items = 0;
    idle_pct = 26;
    stall_pct = 26;
    reset_model();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_missing_trigger();
    test_trigger_closes_record();
    test_pre_truncation();
    test_unordered_times();
    test_register_extremes();
    test_peak_before_trigger();
    test_random_records();

    settle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/tswc_pkg.sv
rtl/tswc_if.sv
rtl/tswc_cell.sv
rtl/tswc_ring.sv
rtl/triggered_spike_window_capture.sv
tb/sv/triggered_spike_window_capture_tb.sv
